>>> hdl/sorted_address_tag_table_defines.svh
// assertion macros used by the checker of the sorted address tag table
`ifndef SORTED_ADDRESS_TAG_TABLE_DEFINES_SVH
`define SORTED_ADDRESS_TAG_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SATT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SATT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sattab_pkg.sv
`default_nettype none

package sattab_pkg;

  localparam int ADDR_W = 64;
  localparam int TYPE_W = 8;
  localparam int POS_W  = 7;

  localparam logic             MODE_INSERT    = 1'b0;
  localparam logic             MODE_LOOKUP    = 1'b1;
  localparam logic             STATUS_DONE    = 1'b0;
  localparam logic             STATUS_FULL    = 1'b1;
  localparam logic [TYPE_W-1:0] MATCH_ANY_TYPE = 8'd2;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic              ins_en;
    logic [ADDR_W-1:0] key_addr;
    logic [TYPE_W-1:0] key_type;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_WAIT   = 3'b100
  } state_t;

endpackage

`default_nettype wire

>>> hdl/sattab_cell.sv
`default_nettype none

module sattab_cell (
  input  wire logic                          clk,
  input  wire sattab_pkg::cell_cmd_t         cmd,
  input  wire logic                          occupied,
  input  wire logic                          prev_lt,
  input  wire logic [sattab_pkg::ADDR_W-1:0] prev_addr,
  input  wire logic [sattab_pkg::TYPE_W-1:0] prev_type,
  output logic      [sattab_pkg::ADDR_W-1:0] entry_addr,
  output logic      [sattab_pkg::TYPE_W-1:0] entry_type,
  output logic                               lt,
  output logic                               hit
);
  import sattab_pkg::*;

  logic [ADDR_W-1:0] entry_addr_r;
  logic [ADDR_W-1:0] entry_addr_nxt;
  logic [TYPE_W-1:0] entry_type_r;
  logic [TYPE_W-1:0] entry_type_nxt;

  assign lt  = occupied && (entry_addr_r < cmd.key_addr);
  assign hit = occupied && (entry_addr_r == cmd.key_addr) &&
               ((cmd.key_type == MATCH_ANY_TYPE) || (cmd.key_type == entry_type_r));

  assign entry_addr = entry_addr_r;
  assign entry_type = entry_type_r;

  // smaller entries stay, the first other cell takes the key, the rest move up one
  always_comb begin
    entry_addr_nxt = entry_addr_r;
    entry_type_nxt = entry_type_r;
    if (cmd.ins_en && !lt) begin
      if (prev_lt) begin
        entry_addr_nxt = cmd.key_addr;
        entry_type_nxt = cmd.key_type;
      end else begin
        entry_addr_nxt = prev_addr;
        entry_type_nxt = prev_type;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_addr_r <= entry_addr_nxt;
    entry_type_r <= entry_type_nxt;
  end

endmodule

`default_nettype wire

>>> hdl/sattab_tree.sv
`default_nettype none

module sattab_tree #(
  parameter int N = 64
) (
  input  wire logic                                     clk,
  input  wire logic [N-1:0]                             hit,
  output logic                                          found,
  output logic [((($clog2(N)) > 0) ? $clog2(N) : 1)-1:0] first_idx
);
  import sattab_pkg::*;

  localparam int LV = $clog2(N);
  localparam int P  = 1 << LV;
  localparam int IW = (LV > 0) ? LV : 1;

  logic [P-1:0]  any_r [LV+1];
  logic [IW-1:0] idx_r [LV+1][P];

  // leaves
  for (genvar j = 0; j < P; j++) begin : g_leaf
    always_ff @(posedge clk) begin
      if (j < N) begin
        any_r[0][j] <= hit[j];
      end else begin
        any_r[0][j] <= 1'b0;
      end
      idx_r[0][j] <= IW'(j);
    end
  end

  // each level keeps the lower-indexed hit of a pair
  for (genvar l = 1; l <= LV; l++) begin : g_lvl
    for (genvar j = 0; j < (P >> l); j++) begin : g_node
      always_ff @(posedge clk) begin
        any_r[l][j] <= any_r[l-1][2*j] | any_r[l-1][2*j+1];
        idx_r[l][j] <= any_r[l-1][2*j] ? idx_r[l-1][2*j] : idx_r[l-1][2*j+1];
      end
    end
  end

  assign found     = any_r[LV][0];
  assign first_idx = idx_r[LV][0];

endmodule

`default_nettype wire

>>> hdl/sorted_address_tag_table.sv
// Sorted table of TABLE_DEPTH address/type entries held in a chain of cells, one entry per
// cell, kept in ascending address order with the newest of equal addresses first. Each
// transaction gives exactly one result. An insert shifts the chain in the cycle it is
// accepted, and its result then waits in the wait state until the output register is free;
// an insert into a full table changes nothing and returns status 1. A lookup compares the
// key in every cell at once and then finds the lowest hit through a registered binary tree
// of clog2(TABLE_DEPTH) levels; match_position is the hit index plus one, or 0 on a miss.
// One transaction is in flight at a time; the output register lets the next input be
// taken while a result waits. Entries hold no reset value; only occupied cells take part
// in a compare.
`default_nettype none

module sorted_address_tag_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_mode,
  input  wire logic [sattab_pkg::ADDR_W-1:0] in_address,
  input  wire logic [sattab_pkg::TYPE_W-1:0] in_entry_type,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_status,
  output logic      [sattab_pkg::POS_W-1:0]  out_match_position
);
  import sattab_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LV = $clog2(TABLE_DEPTH);
  localparam int IW = (LV > 0) ? LV : 1;
  localparam int SW = ($clog2(LV + 1) > 0) ? $clog2(LV + 1) : 1;
  localparam int PW = ((IW + 1) > POS_W) ? (IW + 1) : POS_W;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic              pend_status_r, pend_status_nxt;
  logic [POS_W-1:0]  pend_pos_r, pend_pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r, out_status_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;

  logic              in_take;
  logic              full;
  logic              out_free;
  cell_cmd_t         cmd;

  logic [ADDR_W-1:0] addr_c [TABLE_DEPTH];
  logic [TYPE_W-1:0] type_c [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt_c;
  logic [TABLE_DEPTH-1:0] hit_c;

  logic              found;
  logic [IW-1:0]     first_idx;
  logic [PW-1:0]     pos_wide;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign full     = (cnt_r == CW'(TABLE_DEPTH));
  assign out_free = !out_valid_r || !out_stall;

  assign cmd.ins_en   = in_take && (in_mode == MODE_INSERT) && !full;
  assign cmd.key_addr = in_address;
  assign cmd.key_type = in_entry_type;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic              prev_lt;
    logic [ADDR_W-1:0] prev_addr;
    logic [TYPE_W-1:0] prev_type;

    if (i == 0) begin : g_head
      assign prev_lt   = 1'b1;
      assign prev_addr = in_address;
      assign prev_type = in_entry_type;
    end else begin : g_link
      assign prev_lt   = lt_c[i-1];
      assign prev_addr = addr_c[i-1];
      assign prev_type = type_c[i-1];
    end

    sattab_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (cnt_r > CW'(i)),
      .prev_lt    (prev_lt),
      .prev_addr  (prev_addr),
      .prev_type  (prev_type),
      .entry_addr (addr_c[i]),
      .entry_type (type_c[i]),
      .lt         (lt_c[i]),
      .hit        (hit_c[i])
    );
  end

  sattab_tree #(.N(TABLE_DEPTH)) u_tree (
    .clk       (clk),
    .hit       (hit_c),
    .found     (found),
    .first_idx (first_idx)
  );

  assign pos_wide = found ? (PW'(first_idx) + PW'(1)) : '0;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    step_nxt        = step_r;
    pend_status_nxt = pend_status_r;
    pend_pos_nxt    = pend_pos_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_pos_nxt     = out_pos_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (in_mode == MODE_INSERT) begin
            pend_status_nxt = full ? STATUS_FULL : STATUS_DONE;
            pend_pos_nxt    = '0;
            if (!full) begin
              cnt_nxt = cnt_r + CW'(1);
            end
            state_nxt = ST_WAIT;
          end else begin
            // tree leaves capture the hits at this edge
            step_nxt  = '0;
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (step_r == SW'(LV)) begin
          pend_status_nxt = STATUS_DONE;
          pend_pos_nxt    = pos_wide[POS_W-1:0];
          state_nxt       = ST_WAIT;
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_pos_nxt    = pend_pos_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r        <= step_nxt;
    pend_status_r <= pend_status_nxt;
    pend_pos_r    <= pend_pos_nxt;
    out_status_r  <= out_status_nxt;
    out_pos_r     <= out_pos_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_match_position = out_pos_r;

endmodule

`default_nettype wire

>>> hdl/sattab_checker.sv
`default_nettype none
`include "sorted_address_tag_table_defines.svh"

module sattab_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic                          out_status,
  input wire logic [sattab_pkg::POS_W-1:0]  out_match_position
);
  import sattab_pkg::*;

  // a result waiting at the output is not withdrawn
  `SATT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // only one transaction in flight
  `SATT_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second transaction taken early")

  // a refused insert never reports a position
  `SATT_ASSERT_NOW(a_full_no_pos, out_valid && (out_status == STATUS_FULL), out_match_position == '0, "refused insert with position")

  // positions stay within the table
  `SATT_ASSERT_NOW(a_pos_range, out_valid, (TABLE_DEPTH > 127) || (int'(out_match_position) <= TABLE_DEPTH), "position beyond table")

endmodule

bind sorted_address_tag_table sattab_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_sattab_checker (.*);

`default_nettype wire
